FILE: design/cdbf_pkg.sv
// Shared types and constants for the chunk-delimiting byte FIFO.
package cdbf_pkg;

    // Fixed widths of the result fields and the chunk parser.
    localparam int COUNT_W = 13;
    localparam int POS_W   = 17;

    // Chunk header decoding.
    localparam logic [4:0] SIZE_CODE_MASK = 5'h1F;
    localparam logic [4:0] EXTENDED_CODE  = 5'd31;
    localparam logic [POS_W-1:0] SHORT_EXTRA = POS_W'(2);
    localparam logic [POS_W-1:0] LONG_EXTRA  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_SIZE    = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(3);
    localparam logic [POS_W-1:0] MIN_CHUNK   = POS_W'(2);

    // Command codes carried by the input word.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_FINISH
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;      // an input word is accepted this cycle
        logic load_out;  // the pending result moves into the output register
    } ctrl_cmd_t;

endpackage

FILE: design/cdbf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cdbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/cdbf_ctrl.sv
// Controller state machine: input acceptance and output register handshake.
module cdbf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output cdbf_pkg::ctrl_cmd_t cmd
);

    cdbf_pkg::ctrl_state_t state_reg;
    cdbf_pkg::ctrl_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdbf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.take     = 1'b0;
        cmd.load_out = 1'b0;
        in_stall     = 1'b1;
        case (state_reg)
            cdbf_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = cdbf_pkg::ST_FINISH;
                end
            end
            cdbf_pkg::ST_FINISH:
            begin
                // The result waits here until the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = cdbf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cdbf_pkg::ST_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // A result only appears after the machine has finished an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == cdbf_pkg::ST_FINISH))
        else $error("output became valid without a finished item");

endmodule

FILE: design/cdbf_datapath.sv
// Datapath: ring pointers, chunk parser, byte store and result registers.
module cdbf_datapath #(
    parameter int DEPTH = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cdbf_pkg::ctrl_cmd_t                 cmd,
    input  logic                                command,
    input  logic [7:0]                          data_in,
    output logic [7:0]                          data_out,
    output logic [1:0]                          status,
    output logic [cdbf_pkg::COUNT_W-1:0]        ready_bytes,
    output logic [cdbf_pkg::COUNT_W-1:0]        stored_bytes
);

    localparam int AW = $clog2(DEPTH);
    localparam int DW = AW + 1;
    localparam int CW = (DW > cdbf_pkg::COUNT_W) ? DW : cdbf_pkg::COUNT_W;
    localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [DW-1:0] RING_SIZE = DW'(DEPTH);
    localparam logic [DW-1:0] FULL_MARK = DW'(DEPTH - 2);

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] cm_ptr_reg, cm_ptr_next;
    logic [cdbf_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [cdbf_pkg::POS_W-1:0] len_reg, len_next;
    logic [7:0]                 lo_reg, lo_next;
    cdbf_pkg::status_t          pend_status_reg, pend_status_next;
    logic                       pend_pop_reg, pend_pop_next;

    logic [7:0]                 data_out_reg;
    logic [1:0]                 status_reg;
    logic [cdbf_pkg::COUNT_W-1:0] ready_reg;
    logic [cdbf_pkg::COUNT_W-1:0] stored_reg;

    logic [DW-1:0] dist_rw, dist_rc;
    logic [CW-1:0] ready_wide, stored_wide;
    logic          is_full, has_ready, do_push, do_pop;
    logic [cdbf_pkg::POS_W-1:0] pos_inc;
    logic [4:0]    size_code;
    logic [7:0]    ram_rdata;

    // Ring distances, from the read pointer forward.
    always_comb
    begin
        dist_rw = {1'b0, wr_ptr_reg} - {1'b0, rd_ptr_reg};
        if (wr_ptr_reg < rd_ptr_reg)
        begin
            dist_rw = dist_rw + RING_SIZE;
        end
        dist_rc = {1'b0, cm_ptr_reg} - {1'b0, rd_ptr_reg};
        if (cm_ptr_reg < rd_ptr_reg)
        begin
            dist_rc = dist_rc + RING_SIZE;
        end
    end

    assign is_full   = (dist_rw >= FULL_MARK);
    assign has_ready = (cm_ptr_reg != rd_ptr_reg);
    assign do_push   = cmd.take && (command == cdbf_pkg::CMD_PUSH) && !is_full;
    assign do_pop    = cmd.take && (command == cdbf_pkg::CMD_POP) && has_ready;
    assign size_code = data_in[4:0] & cdbf_pkg::SIZE_CODE_MASK;
    assign pos_inc   = pos_reg + cdbf_pkg::POS_W'(1);

    always_comb
    begin
        wr_ptr_next      = wr_ptr_reg;
        rd_ptr_next      = rd_ptr_reg;
        cm_ptr_next      = cm_ptr_reg;
        pos_next         = pos_reg;
        len_next         = len_reg;
        lo_next          = lo_reg;
        pend_status_next = pend_status_reg;
        pend_pop_next    = pend_pop_reg;

        if (cmd.take)
        begin
            pend_pop_next    = do_pop;
            pend_status_next = cdbf_pkg::STATUS_OK;
            if (command == cdbf_pkg::CMD_PUSH && is_full)
            begin
                pend_status_next = cdbf_pkg::STATUS_FULL;
            end
            else if (command == cdbf_pkg::CMD_POP && !has_ready)
            begin
                pend_status_next = cdbf_pkg::STATUS_EMPTY;
            end
        end

        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + AW'(1);

            // Header decoding as the chunk's bytes arrive.
            if (pos_reg == cdbf_pkg::POS_SIZE)
            begin
                len_next = (size_code == cdbf_pkg::EXTENDED_CODE) ? '0 :
                           cdbf_pkg::POS_W'(size_code) + cdbf_pkg::SHORT_EXTRA;
            end
            else if (pos_reg == cdbf_pkg::POS_LEN_LO && len_reg == '0)
            begin
                lo_next = data_in;
            end
            else if (pos_reg == cdbf_pkg::POS_LEN_HI && len_reg == '0)
            begin
                len_next = cdbf_pkg::POS_W'({data_in, lo_reg}) + cdbf_pkg::LONG_EXTRA;
            end

            pos_next = pos_inc;
            if (pos_inc >= cdbf_pkg::MIN_CHUNK && len_next != '0 && pos_inc >= len_next)
            begin
                // The chunk is complete: everything written so far may be popped.
                cm_ptr_next = wr_ptr_next;
                pos_next    = '0;
                len_next    = '0;
                lo_next     = '0;
            end
        end

        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            cm_ptr_reg      <= '0;
            pos_reg         <= '0;
            len_reg         <= '0;
            lo_reg          <= '0;
            pend_status_reg <= cdbf_pkg::STATUS_OK;
            pend_pop_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            cm_ptr_reg      <= cm_ptr_next;
            pos_reg         <= pos_next;
            len_reg         <= len_next;
            lo_reg          <= lo_next;
            pend_status_reg <= pend_status_next;
            pend_pop_reg    <= pend_pop_next;
        end
    end

    cdbf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (do_push),
        .waddr (wr_ptr_reg),
        .wdata (data_in),
        .re    (do_pop),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign ready_wide  = CW'(dist_rc);
    assign stored_wide = CW'(dist_rw);

    // Result register; the counts already reflect the finished item.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            data_out_reg <= pend_pop_reg ? ram_rdata : 8'h00;
            status_reg   <= pend_status_reg;
            ready_reg    <= ready_wide[cdbf_pkg::COUNT_W-1:0];
            stored_reg   <= stored_wide[cdbf_pkg::COUNT_W-1:0];
        end
    end

    assign data_out     = data_out_reg;
    assign status       = status_reg;
    assign ready_bytes  = ready_reg;
    assign stored_bytes = stored_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        dist_rc <= dist_rw)
        else $error("committed bytes exceed stored bytes");

    assert property (@(posedge clk) disable iff (!rst_n)
        dist_rw <= FULL_MARK)
        else $error("ring holds more than its limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != '0) |-> (pos_reg < len_reg))
        else $error("chunk position ran past a known chunk length");

endmodule

FILE: design/chunk_delimiting_byte_fifo_core.sv
// Top level of the chunk-delimiting byte FIFO.
// A taken word's result is loaded into the output register once that register is free.
// No new word is taken until the last result has entered the output register.
// A result that waits on a stalled output holds the next word off until it moves on.
// Reset (rst_n, asynchronous, active low) clears all pointers and the chunk parser.
// The byte store is not cleared; only committed bytes, which are always written, are read.
module chunk_delimiting_byte_fifo_core #(
    parameter int DEPTH = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         command,
    input  logic [7:0]                   data_in,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [7:0]                   data_out,
    output logic [1:0]                   status,
    output logic [cdbf_pkg::COUNT_W-1:0] ready_bytes,
    output logic [cdbf_pkg::COUNT_W-1:0] stored_bytes
);

    // The controller decides when a word is taken and when its result is
    // published; the datapath carries out the push or pop in the same cycle
    // that the word is taken.
    cdbf_pkg::ctrl_cmd_t cmd;

    cdbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // The datapath owns the ring pointers, the incremental chunk parser, the
    // byte store and the output payload register. A pop reads the store in
    // the take cycle; its byte is ready for the output register in the next cycle.
    cdbf_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .command      (command),
        .data_in      (data_in),
        .data_out     (data_out),
        .status       (status),
        .ready_bytes  (ready_bytes),
        .stored_bytes (stored_bytes)
    );

endmodule

FILE: tb/tb_top.sv
// Testbench for the chunk-delimiting byte FIFO: directed and random words against a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // The ring size the block is built with.
    // The predictor's pointers wrap naturally because it is a power of two.
    localparam int RING_DEPTH = 4096;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int RING_LIMIT = RING_DEPTH - 2;

    // Cycles with no word moving on either side before the run is abandoned.
    // This is far beyond the longest gap that the idling percentages can produce.
    localparam int HANG_LIMIT = 4000;

    // Random words issued in each idling phase, about 1250 in all.
    localparam int PHASE_WORDS = 312;

    typedef struct {
        logic [7:0]                   data;
        cdbf_pkg::status_t            status;
        logic [cdbf_pkg::COUNT_W-1:0] ready;
        logic [cdbf_pkg::COUNT_W-1:0] stored;
    } fifo_result_t;

    // Predicts the block's result for every accepted word.
    // It keeps its own copy of the ring, the pointers and the chunk parser.
    // Results from the block are matched in order against the oldest prediction.
    class fifo_scoreboard;
        logic [7:0]                 ring [RING_DEPTH];
        logic [PTR_W-1:0]           wr_ptr;
        logic [PTR_W-1:0]           rd_ptr;
        logic [PTR_W-1:0]           commit_ptr;
        logic [cdbf_pkg::POS_W-1:0] chunk_pos;
        logic [cdbf_pkg::POS_W-1:0] chunk_len;
        logic [7:0]                 len_low;
        fifo_result_t               awaited [$];
        int unsigned                errors;

        function new();
            wr_ptr     = '0;
            rd_ptr     = '0;
            commit_ptr = '0;
            chunk_pos  = '0;
            chunk_len  = '0;
            len_low    = '0;
            errors     = 0;
        endfunction

        function logic [cdbf_pkg::COUNT_W-1:0] span(logic [PTR_W-1:0] from_ptr,
                                                    logic [PTR_W-1:0] to_ptr);
            logic [PTR_W-1:0] gap;
            gap = to_ptr - from_ptr;
            return cdbf_pkg::COUNT_W'(gap);
        endfunction

        function logic [cdbf_pkg::COUNT_W-1:0] stored_count();
            return span(rd_ptr, wr_ptr);
        endfunction

        function logic [cdbf_pkg::COUNT_W-1:0] ready_count();
            return span(rd_ptr, commit_ptr);
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Applies one accepted word and queues the result it must produce.
        function void note_word(logic cmd, logic [7:0] data);
            fifo_result_t r;
            r.data   = 8'h00;
            r.status = cdbf_pkg::STATUS_OK;
            if (cmd == cdbf_pkg::CMD_PUSH)
            begin
                if (span(rd_ptr, wr_ptr) >= cdbf_pkg::COUNT_W'(RING_LIMIT))
                begin
                    // A full ring drops the byte and leaves the parser alone.
                    r.status = cdbf_pkg::STATUS_FULL;
                end
                else
                begin
                    ring[wr_ptr] = data;
                    wr_ptr = wr_ptr + PTR_W'(1);
                    if (chunk_pos == cdbf_pkg::POS_SIZE)
                    begin
                        chunk_len = (data[4:0] == cdbf_pkg::EXTENDED_CODE) ? '0 :
                                    cdbf_pkg::POS_W'(data[4:0]) + cdbf_pkg::SHORT_EXTRA;
                    end
                    else if (chunk_pos == cdbf_pkg::POS_LEN_LO && chunk_len == '0)
                    begin
                        len_low = data;
                    end
                    else if (chunk_pos == cdbf_pkg::POS_LEN_HI && chunk_len == '0)
                    begin
                        chunk_len = cdbf_pkg::POS_W'({data, len_low}) + cdbf_pkg::LONG_EXTRA;
                    end
                    chunk_pos = chunk_pos + cdbf_pkg::POS_W'(1);
                    if (chunk_pos >= cdbf_pkg::MIN_CHUNK && chunk_len != '0 &&
                        chunk_pos >= chunk_len)
                    begin
                        commit_ptr = wr_ptr;
                        chunk_pos  = '0;
                        chunk_len  = '0;
                        len_low    = '0;
                    end
                end
            end
            else if (commit_ptr == rd_ptr)
            begin
                r.status = cdbf_pkg::STATUS_EMPTY;
            end
            else
            begin
                r.data = ring[rd_ptr];
                rd_ptr = rd_ptr + PTR_W'(1);
            end
            r.ready  = span(rd_ptr, commit_ptr);
            r.stored = span(rd_ptr, wr_ptr);
            awaited.push_back(r);
        endfunction

        function void check_result(logic [7:0] d, logic [1:0] s,
                                   logic [cdbf_pkg::COUNT_W-1:0] rb,
                                   logic [cdbf_pkg::COUNT_W-1:0] st);
            fifo_result_t e;
            if (awaited.size() == 0)
            begin
                $error("result word with nothing awaited: data_out %0d status %0d", d, s);
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (d !== e.data)
            begin
                $error("data_out: expected %0d, got %0d", e.data, d);
                errors++;
            end
            if (s !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, s);
                errors++;
            end
            if (rb !== e.ready)
            begin
                $error("ready_bytes: expected %0d, got %0d", e.ready, rb);
                errors++;
            end
            if (st !== e.stored)
            begin
                $error("stored_bytes: expected %0d, got %0d", e.stored, st);
                errors++;
            end
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic                         command;
    logic [7:0]                   data_in;
    logic                         out_valid;
    logic                         out_stall;
    logic [7:0]                   data_out;
    logic [1:0]                   status;
    logic [cdbf_pkg::COUNT_W-1:0] ready_bytes;
    logic [cdbf_pkg::COUNT_W-1:0] stored_bytes;

    fifo_scoreboard sb;

    // Percent of cycles in which the sender holds back or the receiver stalls.
    int send_idle_pct;
    int stall_pct;
    int words_sent;
    int hang_count;

    chunk_delimiting_byte_fifo_core #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .data_in     (data_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_out    (data_out),
        .status      (status),
        .ready_bytes (ready_bytes),
        .stored_bytes(stored_bytes)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The receiver decides each cycle, at the falling edge, whether to stall.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Every result word that leaves the block is checked at the edge that takes it.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(data_out, status, ready_bytes, stored_bytes);
        end
    end

    // The watchdog ends a run in which no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                hang_count = 0;
            end
            else
            begin
                hang_count = hang_count + 1;
            end
            if (hang_count >= HANG_LIMIT)
            begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // Offers one word, with random idle cycles first, and waits until the block takes it.
    // The word is applied to the predictor at the very edge at which it is accepted.
    task automatic send_word(input logic cmd, input logic [7:0] data);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        data_in  <= data;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_word(cmd, data);
        words_sent++;
    endtask

    task automatic pop_word();
        send_word(cdbf_pkg::CMD_POP, 8'($urandom));
    endtask

    // Pops every committed byte that is waiting.
    task automatic drain_ready();
        while (sb.ready_count() != 0) pop_word();
    endtask

    // Pushes one chunk byte with random pops mixed in.
    // The ring is kept well short of full, so no push is dropped here and the
    // parser in the block stays aligned with the chunks being generated.
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < 50 || sb.stored_count() > 3000) pop_word();
        send_word(cdbf_pkg::CMD_PUSH, b);
    endtask

    // One random piece of traffic: most are well-formed chunks with random
    // content and random upper bits in the size byte, the rest are pop bursts
    // that often find nothing committed.
    task automatic random_chunk();
        int unsigned pick;
        int unsigned body;
        logic [4:0]  code;
        logic [15:0] ext_len;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            repeat ($urandom_range(1, 6)) pop_word();
        end
        else
        begin
            push_byte(8'($urandom));
            if (pick < 70)
            begin
                code = 5'($urandom_range(0, 30));
                push_byte({3'($urandom), code});
                body = code;
            end
            else
            begin
                // Extended sizes are mostly short; a few reach a few hundred bytes.
                ext_len = (pick < 95) ? 16'($urandom_range(0, 40)) :
                                        16'($urandom_range(0, 700));
                push_byte({3'($urandom), cdbf_pkg::EXTENDED_CODE});
                push_byte(ext_len[7:0]);
                push_byte(ext_len[15:8]);
                body = ext_len;
            end
            repeat (body) push_byte(8'($urandom));
        end
    endtask

    task automatic random_phase(input int idle_pct, input int stall_rate);
        int target;
        send_idle_pct = idle_pct;
        stall_pct     = stall_rate;
        target        = words_sent + PHASE_WORDS;
        // Each phase ends on a chunk boundary so the next one starts clean.
        while (words_sent < target) random_chunk();
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        command       = cdbf_pkg::CMD_PUSH;
        data_in       = 8'h00;
        out_stall     = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        words_sent    = 0;
        hang_count    = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening. A pop on the empty ring comes first.
        pop_word();
        // The shortest chunk: size code zero, with the upper size bits set.
        send_word(cdbf_pkg::CMD_PUSH, 8'h00);
        send_word(cdbf_pkg::CMD_PUSH, 8'hE0);
        // A three-byte chunk with all-ones id.
        send_word(cdbf_pkg::CMD_PUSH, 8'hFF);
        send_word(cdbf_pkg::CMD_PUSH, 8'h01);
        send_word(cdbf_pkg::CMD_PUSH, 8'h5A);
        pop_word();
        pop_word();
        // Extended size with a zero length field: the header alone is the chunk.
        send_word(cdbf_pkg::CMD_PUSH, 8'h7F);
        send_word(cdbf_pkg::CMD_PUSH, {3'b111, cdbf_pkg::EXTENDED_CODE});
        send_word(cdbf_pkg::CMD_PUSH, 8'h00);
        send_word(cdbf_pkg::CMD_PUSH, 8'h00);
        // An extended chunk that is left open while everything committed is popped.
        // The pop after that must report empty although partial bytes are held.
        send_word(cdbf_pkg::CMD_PUSH, 8'h11);
        send_word(cdbf_pkg::CMD_PUSH, {3'b000, cdbf_pkg::EXTENDED_CODE});
        send_word(cdbf_pkg::CMD_PUSH, 8'h02);
        repeat (7) pop_word();
        pop_word();
        send_word(cdbf_pkg::CMD_PUSH, 8'h00);
        send_word(cdbf_pkg::CMD_PUSH, 8'hA5);
        send_word(cdbf_pkg::CMD_PUSH, 8'hC3);
        drain_ready();

        // Random traffic under each idling pattern.
        random_phase(0, 0);
        random_phase(88, 0);
        random_phase(0, 88);
        random_phase(32, 32);

        send_idle_pct = 0;
        stall_pct     = 0;
        drain_ready();

        @(negedge clk);
        in_valid <= 1'b0;
        // Wait for the last results, then a few cycles more for any stray word.
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.errors == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
